// ===== rtl/umix_pkg.sv =====
// ----------------------------------------------------------------------------
// Unicycle to wheel PWM mixer package
// Register indexes, reset values, datapath widths and the output saturation
// helper shared by the mixer RTL.
// ----------------------------------------------------------------------------
package umix_pkg;

   // Configuration register indexes.
   typedef enum logic [2:0] {
      REG_INV_RADIUS  = 3'd0,
      REG_HALF_TRACK  = 3'd1,
      REG_PWM_SLOPE   = 3'd2,
      REG_PWM_OFFSET  = 3'd3,
      REG_DEADBAND    = 3'd4,
      REG_DIFF_LIMIT  = 3'd5,
      REG_SPIN_LIMIT  = 3'd6
   } reg_index_type;

   localparam int CsrIndexWidth = 3;
   localparam int CsrDataWidth  = 16;

   localparam logic [15:0] InvRadiusReset  = 16'd8205;
   localparam logic [15:0] HalfTrackReset  = 16'd5308;
   localparam logic [15:0] PwmSlopeReset   = 16'd1603;
   localparam logic [7:0]  PwmOffsetReset  = 8'd47;
   localparam logic [15:0] DeadbandReset   = 16'd128;
   localparam logic [9:0]  DiffLimitReset  = 10'd80;
   localparam logic [9:0]  SpinLimitReset  = 10'd80;

   // Number of register stages from an accepted command to the result strobe.
   localparam int PipeDepth = 8;

   localparam int PwmWidth = 11;
   localparam logic signed [24:0] PwmMax = 25'sd1023;

   // Clamp a wide signed PWM value to the symmetric output range.
   function automatic logic signed [PwmWidth-1:0] sat_pwm(input logic signed [24:0] x);
      logic signed [24:0] y;
      begin
         y = x;
         if (x > PwmMax) begin
            y = PwmMax;
         end else if (x < -PwmMax) begin
            y = -PwmMax;
         end
         return y[PwmWidth-1:0];
      end
   endfunction

endpackage

// ===== rtl/unicycle_to_wheel_pwm_mixer.sv =====
// ----------------------------------------------------------------------------
// Unicycle to wheel PWM mixer
// Turns a forward speed and turn rate into a signed left/right motor PWM pair.
// ----------------------------------------------------------------------------
// Usage:
//   A command (linear velocity and turn rate, both signed Q4.12) is taken at
//   a rising edge where start is high and busy is low. busy is held low: the
//   block is a free-running pipeline and takes a new transaction every cycle.
//   Each transaction gives exactly one result: rsp_left_pwm and rsp_right_pwm
//   are shown for one cycle with rsp_valid high once the command has passed
//   through the pipeline. The eight stages are: turn-rate product, wheel
//   numerators, radius product, truncation to Q8.8, opposite-wheel and
//   deadband logic, slope product, offset and sign, then limits and
//   saturation. The receiver cannot stall the block; results are not held.
//   Configuration is to be written by the user via csr_we/csr_index/csr_wdata
//   only while no transaction is in flight; the block does not enforce it.
//   Unknown indexes are ignored. Reset is synchronous: it clears all valid
//   bits, so nothing in flight is delivered, and loads every configuration
//   register with its documented default.
// ----------------------------------------------------------------------------
module unicycle_to_wheel_pwm_mixer
   import umix_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic signed [15:0]          req_linear_velocity,
   input  logic signed [15:0]          req_turn_rate,
   output logic                        rsp_valid,
   output logic signed [PwmWidth-1:0]  rsp_left_pwm,
   output logic signed [PwmWidth-1:0]  rsp_right_pwm,
   input  logic                        csr_we,
   input  logic [CsrIndexWidth-1:0]    csr_index,
   input  logic [CsrDataWidth-1:0]     csr_wdata
);

   // Configuration registers.
   logic [15:0] inv_radius_ff;
   logic [15:0] half_track_ff;
   logic [15:0] pwm_slope_ff;
   logic [7:0]  pwm_offset_ff;
   logic [15:0] deadband_ff;
   logic [9:0]  diff_limit_ff;
   logic [9:0]  spin_limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         inv_radius_ff <= InvRadiusReset;
         half_track_ff <= HalfTrackReset;
         pwm_slope_ff  <= PwmSlopeReset;
         pwm_offset_ff <= PwmOffsetReset;
         deadband_ff   <= DeadbandReset;
         diff_limit_ff <= DiffLimitReset;
         spin_limit_ff <= SpinLimitReset;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_INV_RADIUS: inv_radius_ff <= csr_wdata;
            REG_HALF_TRACK: half_track_ff <= csr_wdata;
            REG_PWM_SLOPE:  pwm_slope_ff  <= csr_wdata;
            REG_PWM_OFFSET: pwm_offset_ff <= csr_wdata[7:0];
            REG_DEADBAND:   deadband_ff   <= csr_wdata;
            REG_DIFF_LIMIT: diff_limit_ff <= csr_wdata[9:0];
            REG_SPIN_LIMIT: spin_limit_ff <= csr_wdata[9:0];
            default: ;
         endcase
      end
   end

   assign busy = 1'b0;

   logic                 accept;
   logic [PipeDepth-1:0] valid_ff;
   logic [PipeDepth-1:0] valid_in;

   assign accept   = start & ~busy;
   assign valid_in = {valid_ff[PipeDepth-2:0], accept};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign rsp_valid = valid_ff[PipeDepth-1];

   // Stage 1: turn rate times half track (Q4.28).
   logic signed [15:0] v1_ff;
   logic signed [32:0] wt1_ff;
   logic signed [32:0] wt1_in;

   assign wt1_in = req_turn_rate * $signed({1'b0, half_track_ff});

   always_ff @(posedge clock) begin
      v1_ff  <= req_linear_velocity;
      wt1_ff <= wt1_in;
   end

   // Stage 2: wheel numerators v -/+ w*half_track in Q4.28.
   logic signed [33:0] vs2;
   logic signed [33:0] nl2_in, nr2_in;
   logic signed [33:0] nl2_ff, nr2_ff;
   logic               vz2_ff;

   assign vs2    = {{2{v1_ff[15]}}, v1_ff, 16'b0};
   assign nl2_in = vs2 - {wt1_ff[32], wt1_ff};
   assign nr2_in = vs2 + {wt1_ff[32], wt1_ff};

   always_ff @(posedge clock) begin
      nl2_ff <= nl2_in;
      nr2_ff <= nr2_in;
      vz2_ff <= (v1_ff == 16'sd0);
   end

   // Stage 3: times the inverse wheel radius (Q13.36).
   logic signed [50:0] pl3_in, pr3_in;
   logic signed [50:0] pl3_ff, pr3_ff;
   logic               vz3_ff;

   assign pl3_in = nl2_ff * $signed({1'b0, inv_radius_ff});
   assign pr3_in = nr2_ff * $signed({1'b0, inv_radius_ff});

   always_ff @(posedge clock) begin
      pl3_ff <= pl3_in;
      pr3_ff <= pr3_in;
      vz3_ff <= vz2_ff;
   end

   // Stage 4: truncate toward zero to Q8.8 wheel speed.
   logic signed [50:0] bl4, br4;
   logic signed [22:0] sl4_ff, sr4_ff;
   logic               vz4_ff;

   assign bl4 = pl3_ff + (pl3_ff[50] ? 51'sd268435455 : 51'sd0);
   assign br4 = pr3_ff + (pr3_ff[50] ? 51'sd268435455 : 51'sd0);

   always_ff @(posedge clock) begin
      sl4_ff <= bl4[50:28];
      sr4_ff <= br4[50:28];
      vz4_ff <= vz3_ff;
   end

   // Stage 5: stop the slower wheel when driving with opposite wheel signs,
   // then split into magnitude, sign and the deadband decision.
   logic               pos_l5, pos_r5, opp5, l_bigger5;
   logic [21:0]        al5, ar5;
   logic [21:0]        mag_l5_in, mag_r5_in;
   logic [21:0]        mag_l5_ff, mag_r5_ff;
   logic               neg_l5_ff, neg_r5_ff, act_l5_ff, act_r5_ff, vz5_ff;
   logic signed [22:0] negl5, negr5;

   assign pos_l5    = ~sl4_ff[22] & (sl4_ff != 23'sd0);
   assign pos_r5    = ~sr4_ff[22] & (sr4_ff != 23'sd0);
   assign opp5      = ~vz4_ff & ((sl4_ff[22] & pos_r5) | (pos_l5 & sr4_ff[22]));
   assign negl5     = -sl4_ff;
   assign negr5     = -sr4_ff;
   assign al5       = sl4_ff[22] ? negl5[21:0] : sl4_ff[21:0];
   assign ar5       = sr4_ff[22] ? negr5[21:0] : sr4_ff[21:0];
   assign l_bigger5 = al5 > ar5;
   assign mag_l5_in = (opp5 & ~l_bigger5) ? 22'd0 : al5;
   assign mag_r5_in = (opp5 & l_bigger5) ? 22'd0 : ar5;

   always_ff @(posedge clock) begin
      mag_l5_ff <= mag_l5_in;
      mag_r5_ff <= mag_r5_in;
      neg_l5_ff <= sl4_ff[22] & ~(opp5 & ~l_bigger5);
      neg_r5_ff <= sr4_ff[22] & ~(opp5 & l_bigger5);
      act_l5_ff <= mag_l5_in >= {6'd0, deadband_ff};
      act_r5_ff <= mag_r5_in >= {6'd0, deadband_ff};
      vz5_ff    <= vz4_ff;
   end

   // Stage 6: slope times speed magnitude (Q16.16 counts).
   logic [37:0] ml6_ff, mr6_ff;
   logic        neg_l6_ff, neg_r6_ff, act_l6_ff, act_r6_ff, vz6_ff;

   always_ff @(posedge clock) begin
      ml6_ff    <= pwm_slope_ff * mag_l5_ff;
      mr6_ff    <= pwm_slope_ff * mag_r5_ff;
      neg_l6_ff <= neg_l5_ff;
      neg_r6_ff <= neg_r5_ff;
      act_l6_ff <= act_l5_ff;
      act_r6_ff <= act_r5_ff;
      vz6_ff    <= vz5_ff;
   end

   // Stage 7: drop the fraction, add the offset and apply the sign; zero below the deadband.
   logic [22:0]        ul7, ur7;
   logic signed [23:0] pl7_in, pr7_in;
   logic signed [23:0] pl7_ff, pr7_ff;
   logic               vz7_ff;

   assign ul7 = act_l6_ff ? ({1'b0, ml6_ff[37:16]} + {15'd0, pwm_offset_ff}) : 23'd0;
   assign ur7 = act_r6_ff ? ({1'b0, mr6_ff[37:16]} + {15'd0, pwm_offset_ff}) : 23'd0;
   assign pl7_in = neg_l6_ff ? -$signed({1'b0, ul7}) : $signed({1'b0, ul7});
   assign pr7_in = neg_r6_ff ? -$signed({1'b0, ur7}) : $signed({1'b0, ur7});

   always_ff @(posedge clock) begin
      pl7_ff <= pl7_in;
      pr7_ff <= pr7_in;
      vz7_ff <= vz6_ff;
   end

   // Stage 8: spin clamp or left-right difference limit, then saturation.
   logic signed [24:0] pl8, pr8, d8, sp8, al8, dif8;
   logic signed [24:0] fl8, fr8;

   always_comb begin
      pl8  = {pl7_ff[23], pl7_ff};
      pr8  = {pr7_ff[23], pr7_ff};
      d8   = {15'd0, diff_limit_ff};
      sp8  = {15'd0, spin_limit_ff};
      al8  = pl8[24] ? -pl8 : pl8;
      dif8 = pl8 - pr8;
      fl8  = pl8;
      fr8  = pr8;
      if (vz7_ff) begin
         if (al8 > sp8) begin
            if (pl8 > 25'sd0) begin
               fl8 = sp8;
               fr8 = -sp8;
            end else begin
               fl8 = -sp8;
               fr8 = sp8;
            end
         end
      end else begin
         if (dif8 > d8) begin
            if (pl8 > 25'sd0) begin
               fl8 = pr8 + d8;
            end else begin
               fr8 = pl8 - d8;
            end
         end else if (dif8 < -d8) begin
            if (pl8 >= 25'sd0) begin
               fr8 = pl8 + d8;
            end else begin
               fl8 = pr8 - d8;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_left_pwm  <= sat_pwm(fl8);
      rsp_right_pwm <= sat_pwm(fr8);
   end

endmodule
